### rtl/core/lls_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the 3x3 lup linear solver
// no dependencies; imported by every other file but lls_fifo

package lls_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CMD_Q_DEPTH   = 4;
   localparam int RSP_Q_DEPTH   = 2;

   // wide width for sums of shifted products before saturation
   localparam int WIDE_W = 66;
   localparam logic signed [WIDE_W-1:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [WIDE_W-1:0] SAT_MIN = -66'sd2147483648;

   typedef struct packed {
      logic signed [31:0] a11;
      logic signed [31:0] a12;
      logic signed [31:0] a13;
      logic signed [31:0] a21;
      logic signed [31:0] a22;
      logic signed [31:0] a23;
      logic signed [31:0] a31;
      logic signed [31:0] a32;
      logic signed [31:0] a33;
      logic signed [31:0] b1;
      logic signed [31:0] b2;
      logic signed [31:0] b3;
   } lls_req_type;

   typedef struct packed {
      logic signed [31:0] x1;
      logic signed [31:0] x2;
      logic signed [31:0] x3;
      logic               singular;
      logic               overflow;
   } lls_rsp_type;

   // working context of one system as it travels down the back end
   typedef struct packed {
      logic [2:0][2:0][31:0] m;
      logic [2:0][31:0]      b;
      logic [2:0][31:0]      y;
      logic [2:0][31:0]      x;
      logic [31:0]           t;
      logic [3:0][63:0]      p;
      logic                  sing;
      logic                  ovf;
   } lls_ctx_type;

   function automatic logic [32:0] abs33(input logic [31:0] v);
      logic signed [32:0] s;
      s = 33'($signed(v));
      return s[32] ? 33'(-s) : 33'(s);
   endfunction

   // returns {saturated flag, clamped value}
   function automatic logic [32:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic [32:0] r;
      if (v > SAT_MAX) begin
         r = {1'b1, 32'h7fff_ffff};
      end else if (v < SAT_MIN) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

### rtl/core/lup_linear_solve_3x3_unit.sv
`timescale 1ns / 1ps
// 3x3 linear solver: lup decomposition with partial pivoting, signed fixed point
// usage notes below; depends on lls_pkg, lls_front, lls_fifo, lls_back
//
// Input side is a queue: drive req_data and raise req_push; the item is taken on a
// clock edge where req_full is low. Results come out of a queue: while rsp_empty is
// low rsp_data holds the oldest solution, taken on an edge where rsp_pop is high.
// The front end picks the first pivot and exchanges rows as an item enters a
// four-deep queue; the back end drains that queue into a fixed pipeline holding
// six restoring dividers of FRAC_BITS+33 stages each plus thirteen stages of
// multiply and subtract. One item is accepted and one result delivered every
// cycle while the back end is not stalled by a full result queue.
// The latency is set by the chain of dividers, one quotient bit per stage.
// The whole back end advances only while the two-entry result queue has room, so
// a receiver that stops popping freezes it, then the input queue fills and
// req_full rises; nothing is dropped. Synchronous reset empties both queues and
// clears every pipeline valid bit; no clearing pass is needed.

module lup_linear_solve_3x3_unit #(
   parameter int FRAC_BITS = lls_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  lls_pkg::lls_req_type req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output lls_pkg::lls_rsp_type rsp_data
);

   import lls_pkg::*;

   lls_ctx_type front_ctx, cmd_head;
   logic        cmd_empty, cmd_pop;
   logic        rsp_q_full, rsp_q_push;
   lls_rsp_type back_rsp;

   lls_front u_front (
      .req (req_data),
      .ctx (front_ctx)
   );

   lls_fifo #(
      .DEPTH     (CMD_Q_DEPTH),
      .item_type (lls_ctx_type)
   ) u_cmd_q (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .full     (req_full),
      .data_in  (front_ctx),
      .pop      (cmd_pop),
      .empty    (cmd_empty),
      .data_out (cmd_head)
   );

   lls_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_empty (cmd_empty),
      .in_item  (cmd_head),
      .in_pop   (cmd_pop),
      .out_full (rsp_q_full),
      .out_push (rsp_q_push),
      .out_item (back_rsp)
   );

   lls_fifo #(
      .DEPTH     (RSP_Q_DEPTH),
      .item_type (lls_rsp_type)
   ) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_q_push),
      .full     (rsp_q_full),
      .data_in  (back_rsp),
      .pop      (rsp_pop),
      .empty    (rsp_empty),
      .data_out (rsp_data)
   );

endmodule

### rtl/core/lls_fifo.sv
`timescale 1ns / 1ps
// small register queue with push/full and pop/empty sides
// depends on nothing but its type parameter

module lls_fifo #(
   parameter int  DEPTH     = 4,
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  item_type data_in,
   input  logic     pop,
   output logic     empty,
   output item_type data_out
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type        mem_ff [DEPTH];
   logic [AW:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW:0]     rd_ptr_ff, rd_ptr_in;
   logic            do_push, do_pop;

   assign empty    = (wr_ptr_ff == rd_ptr_ff);
   assign full     = (wr_ptr_ff[AW] != rd_ptr_ff[AW]) &&
                     (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = mem_ff[rd_ptr_ff[AW-1:0]];

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff[AW-1:0]] <= data_in;
      end
   end

endmodule

### rtl/core/lls_front.sv
`timescale 1ns / 1ps
// front end: first pivot search and row exchange on an incoming item
// depends on lls_pkg

module lls_front (
   input  lls_pkg::lls_req_type req,
   output lls_pkg::lls_ctx_type ctx
);

   import lls_pkg::*;

   logic [32:0] mag0, mag1, mag2, best;
   logic [1:0]  pick;
   logic [2:0][2:0][31:0] rows;
   logic [2:0][31:0]      rhs;

   assign rows[0] = {req.a13, req.a12, req.a11};
   assign rows[1] = {req.a23, req.a22, req.a21};
   assign rows[2] = {req.a33, req.a32, req.a31};
   assign rhs     = {req.b3, req.b2, req.b1};

   assign mag0 = abs33(req.a11);
   assign mag1 = abs33(req.a21);
   assign mag2 = abs33(req.a31);

   // first row of largest magnitude wins
   always_comb begin
      best = mag0;
      pick = 2'd0;
      if (mag1 > best) begin
         best = mag1;
         pick = 2'd1;
      end
      if (mag2 > best) begin
         best = mag2;
         pick = 2'd2;
      end
   end

   always_comb begin
      ctx      = '0;
      ctx.m    = rows;
      ctx.b    = rhs;
      ctx.sing = (best == '0);
      if (pick != 2'd0) begin
         ctx.m[0]    = rows[pick];
         ctx.m[pick] = rows[0];
         ctx.b[0]    = rhs[pick];
         ctx.b[pick] = rhs[0];
      end
   end

endmodule

### rtl/core/lls_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider: q = (num << FRAC_BITS) / den, truncated toward zero,
// saturated to 32 bits, one quotient bit per stage; depends on lls_pkg

module lls_div #(
   parameter int  FRAC_BITS = lls_pkg::FRAC_BITS_DEF,
   parameter type side_type = logic
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [31:0] num,
   input  logic [31:0] den,
   input  side_type    side_in,
   output logic        out_valid,
   output logic [31:0] quo,
   output logic        ovf,
   output side_type    side_out
);

   import lls_pkg::*;

   localparam int QW = 32 + FRAC_BITS;

   logic [QW:0]    vld_ff, vld_in;
   logic [31:0]    rem_ff [QW+1];
   logic [31:0]    rem_in [QW+1];
   logic [QW-1:0]  dq_ff [QW+1];
   logic [QW-1:0]  dq_in [QW+1];
   logic [31:0]    dm_ff [QW+1];
   logic [QW:0]    neg_ff, dz_ff;
   side_type       side_ff [QW+1];
   logic [31:0]    nmag, dmag;
   logic [QW-1:0]  mag;

   assign nmag = num[31] ? 32'(-num) : num;
   assign dmag = den[31] ? 32'(-den) : den;

   always_comb begin
      logic [32:0] trial;
      vld_in = {vld_ff[QW-1:0], in_valid};
      rem_in[0] = '0;
      dq_in[0]  = {nmag, {FRAC_BITS{1'b0}}};
      for (int i = 1; i <= QW; i++) begin
         trial = {rem_ff[i-1], dq_ff[i-1][QW-1]};
         if (trial >= {1'b0, dm_ff[i-1]}) begin
            rem_in[i] = 32'(trial - {1'b0, dm_ff[i-1]});
            dq_in[i]  = {dq_ff[i-1][QW-2:0], 1'b1};
         end else begin
            rem_in[i] = trial[31:0];
            dq_in[i]  = {dq_ff[i-1][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dm_ff[0]   <= dmag;
         neg_ff[0]  <= num[31] ^ den[31];
         dz_ff[0]   <= (den == '0);
         side_ff[0] <= side_in;
         for (int i = 0; i <= QW; i++) begin
            rem_ff[i] <= rem_in[i];
            dq_ff[i]  <= dq_in[i];
         end
         for (int i = 1; i <= QW; i++) begin
            dm_ff[i]   <= dm_ff[i-1];
            neg_ff[i]  <= neg_ff[i-1];
            dz_ff[i]   <= dz_ff[i-1];
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign mag       = dq_ff[QW];
   assign out_valid = vld_ff[QW];
   assign side_out  = side_ff[QW];

   // sign, clamp; division by zero gives zero
   always_comb begin
      quo = '0;
      ovf = 1'b0;
      if (dz_ff[QW]) begin
         quo = '0;
      end else if (neg_ff[QW]) begin
         if (mag > QW'(33'h1_0000_0000 >> 1)) begin
            quo = 32'h8000_0000;
            ovf = 1'b1;
         end else begin
            quo = 32'(-mag);
         end
      end else begin
         if (mag > QW'(32'h7fff_ffff)) begin
            quo = 32'h7fff_ffff;
            ovf = 1'b1;
         end else begin
            quo = mag[31:0];
         end
      end
   end

endmodule

### rtl/core/lls_back.sv
`timescale 1ns / 1ps
// back end: elimination, second pivot, forward and backward substitution
// depends on lls_pkg and lls_div

module lls_back #(
   parameter int FRAC_BITS = lls_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_empty,
   input  lls_pkg::lls_ctx_type in_item,
   output logic                 in_pop,
   input  logic                 out_full,
   output logic                 out_push,
   output lls_pkg::lls_rsp_type out_item
);

   import lls_pkg::*;

   localparam int S_PRD1 = 0;
   localparam int S_UPD1 = 1;
   localparam int S_PIV2 = 2;
   localparam int S_PRD2 = 3;
   localparam int S_UPD2 = 4;
   localparam int S_FWD1 = 5;
   localparam int S_FWD2 = 6;
   localparam int S_FWD3 = 7;
   localparam int S_FWD4 = 8;
   localparam int S_BK1  = 9;
   localparam int S_BK2  = 10;
   localparam int S_BK3  = 11;
   localparam int S_BK4  = 12;
   localparam int NST    = 13;
   localparam int NDIV   = 6;

   logic              en;
   lls_ctx_type       st_ff [NST];
   lls_ctx_type       st_in [NST];
   logic [NST-1:0]    vld_ff, vld_in;

   logic [NDIV-1:0]       dv_ivld, dv_ovld, dv_ovf;
   logic [NDIV-1:0][31:0] dv_num, dv_den, dv_quo;
   lls_ctx_type           dv_side_in [NDIV];
   lls_ctx_type           dv_side_out [NDIV];
   lls_ctx_type           dv_ctx [NDIV];

   function automatic logic [63:0] mul64(input logic [31:0] a, input logic [31:0] b);
      logic signed [63:0] r;
      r = $signed(a) * $signed(b);
      return r;
   endfunction

   function automatic logic signed [WIDE_W-1:0] asr_q(input logic [63:0] p);
      logic signed [63:0] s;
      s = $signed(p) >>> FRAC_BITS;
      return WIDE_W'(s);
   endfunction

   function automatic logic signed [WIDE_W-1:0] ext(input logic [31:0] v);
      return WIDE_W'($signed(v));
   endfunction

   // the whole back end moves together while the result queue has room
   assign en     = !out_full;
   assign in_pop = en && !in_empty;

   generate
      for (genvar d = 0; d < NDIV; d++) begin : g_div
         lls_div #(
            .FRAC_BITS (FRAC_BITS),
            .side_type (lls_ctx_type)
         ) u_div (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .in_valid  (dv_ivld[d]),
            .num       (dv_num[d]),
            .den       (dv_den[d]),
            .side_in   (dv_side_in[d]),
            .out_valid (dv_ovld[d]),
            .quo       (dv_quo[d]),
            .ovf       (dv_ovf[d]),
            .side_out  (dv_side_out[d])
         );
      end
   endgenerate

   // fold each quotient back into its context
   always_comb begin
      for (int d = 0; d < NDIV; d++) begin
         dv_ctx[d]     = dv_side_out[d];
         dv_ctx[d].ovf = dv_side_out[d].ovf | dv_ovf[d];
      end
      dv_ctx[0].m[1][0] = dv_quo[0];
      dv_ctx[1].m[2][0] = dv_quo[1];
      dv_ctx[2].m[2][1] = dv_quo[2];
      dv_ctx[3].x[2]    = dv_quo[3];
      dv_ctx[4].x[1]    = dv_quo[4];
      dv_ctx[5].x[0]    = dv_quo[5];
   end

   always_comb begin
      dv_ivld[0]    = !in_empty;
      dv_side_in[0] = in_item;
      dv_num[0]     = in_item.m[1][0];
      dv_den[0]     = in_item.m[0][0];

      dv_ivld[1]    = dv_ovld[0];
      dv_side_in[1] = dv_ctx[0];
      dv_num[1]     = dv_ctx[0].m[2][0];
      dv_den[1]     = dv_ctx[0].m[0][0];

      dv_ivld[2]    = vld_ff[S_PIV2];
      dv_side_in[2] = st_ff[S_PIV2];
      dv_num[2]     = st_ff[S_PIV2].m[2][1];
      dv_den[2]     = st_ff[S_PIV2].m[1][1];

      dv_ivld[3]    = vld_ff[S_FWD4];
      dv_side_in[3] = st_ff[S_FWD4];
      dv_num[3]     = st_ff[S_FWD4].y[2];
      dv_den[3]     = st_ff[S_FWD4].m[2][2];

      dv_ivld[4]    = vld_ff[S_BK2];
      dv_side_in[4] = st_ff[S_BK2];
      dv_num[4]     = st_ff[S_BK2].t;
      dv_den[4]     = st_ff[S_BK2].m[1][1];

      dv_ivld[5]    = vld_ff[S_BK4];
      dv_side_in[5] = st_ff[S_BK4];
      dv_num[5]     = st_ff[S_BK4].t;
      dv_den[5]     = st_ff[S_BK4].m[0][0];
   end

   always_comb begin
      vld_in[S_PRD1] = dv_ovld[1];
      vld_in[S_UPD1] = vld_ff[S_PRD1];
      vld_in[S_PIV2] = vld_ff[S_UPD1];
      vld_in[S_PRD2] = dv_ovld[2];
      vld_in[S_UPD2] = vld_ff[S_PRD2];
      vld_in[S_FWD1] = vld_ff[S_UPD2];
      vld_in[S_FWD2] = vld_ff[S_FWD1];
      vld_in[S_FWD3] = vld_ff[S_FWD2];
      vld_in[S_FWD4] = vld_ff[S_FWD3];
      vld_in[S_BK1]  = dv_ovld[3];
      vld_in[S_BK2]  = vld_ff[S_BK1];
      vld_in[S_BK3]  = dv_ovld[4];
      vld_in[S_BK4]  = vld_ff[S_BK3];
   end

   always_comb begin
      logic [32:0] r0, r1, r2, r3;
      logic [32:0] mg1, mg2;

      // first column update: products
      st_in[S_PRD1]      = dv_ctx[1];
      st_in[S_PRD1].p[0] = mul64(dv_ctx[1].m[1][0], dv_ctx[1].m[0][1]);
      st_in[S_PRD1].p[1] = mul64(dv_ctx[1].m[1][0], dv_ctx[1].m[0][2]);
      st_in[S_PRD1].p[2] = mul64(dv_ctx[1].m[2][0], dv_ctx[1].m[0][1]);
      st_in[S_PRD1].p[3] = mul64(dv_ctx[1].m[2][0], dv_ctx[1].m[0][2]);

      // first column update: subtract and clamp
      r0 = sat32(ext(st_ff[S_PRD1].m[1][1]) - asr_q(st_ff[S_PRD1].p[0]));
      r1 = sat32(ext(st_ff[S_PRD1].m[1][2]) - asr_q(st_ff[S_PRD1].p[1]));
      r2 = sat32(ext(st_ff[S_PRD1].m[2][1]) - asr_q(st_ff[S_PRD1].p[2]));
      r3 = sat32(ext(st_ff[S_PRD1].m[2][2]) - asr_q(st_ff[S_PRD1].p[3]));
      st_in[S_UPD1]         = st_ff[S_PRD1];
      st_in[S_UPD1].m[1][1] = r0[31:0];
      st_in[S_UPD1].m[1][2] = r1[31:0];
      st_in[S_UPD1].m[2][1] = r2[31:0];
      st_in[S_UPD1].m[2][2] = r3[31:0];
      st_in[S_UPD1].ovf     = st_ff[S_PRD1].ovf | r0[32] | r1[32] | r2[32] | r3[32];

      // second pivot: lower row only wins when strictly larger
      mg1 = abs33(st_ff[S_UPD1].m[1][1]);
      mg2 = abs33(st_ff[S_UPD1].m[2][1]);
      st_in[S_PIV2]      = st_ff[S_UPD1];
      st_in[S_PIV2].sing = st_ff[S_UPD1].sing | ((mg1 == '0) && (mg2 == '0));
      if (mg2 > mg1) begin
         st_in[S_PIV2].m[1] = st_ff[S_UPD1].m[2];
         st_in[S_PIV2].m[2] = st_ff[S_UPD1].m[1];
         st_in[S_PIV2].b[1] = st_ff[S_UPD1].b[2];
         st_in[S_PIV2].b[2] = st_ff[S_UPD1].b[1];
      end

      st_in[S_PRD2]      = dv_ctx[2];
      st_in[S_PRD2].p[0] = mul64(dv_ctx[2].m[2][1], dv_ctx[2].m[1][2]);

      r0 = sat32(ext(st_ff[S_PRD2].m[2][2]) - asr_q(st_ff[S_PRD2].p[0]));
      st_in[S_UPD2]         = st_ff[S_PRD2];
      st_in[S_UPD2].m[2][2] = r0[31:0];
      st_in[S_UPD2].ovf     = st_ff[S_PRD2].ovf | r0[32];
      st_in[S_UPD2].sing    = st_ff[S_PRD2].sing | (r0[31:0] == '0);

      // forward substitution
      st_in[S_FWD1]      = st_ff[S_UPD2];
      st_in[S_FWD1].y[0] = st_ff[S_UPD2].b[0];
      st_in[S_FWD1].p[0] = mul64(st_ff[S_UPD2].m[1][0], st_ff[S_UPD2].b[0]);
      st_in[S_FWD1].p[1] = mul64(st_ff[S_UPD2].m[2][0], st_ff[S_UPD2].b[0]);

      r0 = sat32(ext(st_ff[S_FWD1].b[1]) - asr_q(st_ff[S_FWD1].p[0]));
      st_in[S_FWD2]      = st_ff[S_FWD1];
      st_in[S_FWD2].y[1] = r0[31:0];
      st_in[S_FWD2].ovf  = st_ff[S_FWD1].ovf | r0[32];

      st_in[S_FWD3]      = st_ff[S_FWD2];
      st_in[S_FWD3].p[2] = mul64(st_ff[S_FWD2].m[2][1], st_ff[S_FWD2].y[1]);

      r0 = sat32(ext(st_ff[S_FWD3].b[2]) -
                 (asr_q(st_ff[S_FWD3].p[1]) + asr_q(st_ff[S_FWD3].p[2])));
      st_in[S_FWD4]      = st_ff[S_FWD3];
      st_in[S_FWD4].y[2] = r0[31:0];
      st_in[S_FWD4].ovf  = st_ff[S_FWD3].ovf | r0[32];

      // backward substitution
      st_in[S_BK1]      = dv_ctx[3];
      st_in[S_BK1].p[0] = mul64(dv_ctx[3].m[1][2], dv_ctx[3].x[2]);

      r0 = sat32(ext(st_ff[S_BK1].y[1]) - asr_q(st_ff[S_BK1].p[0]));
      st_in[S_BK2]     = st_ff[S_BK1];
      st_in[S_BK2].t   = r0[31:0];
      st_in[S_BK2].ovf = st_ff[S_BK1].ovf | r0[32];

      st_in[S_BK3]      = dv_ctx[4];
      st_in[S_BK3].p[0] = mul64(dv_ctx[4].m[0][1], dv_ctx[4].x[1]);
      st_in[S_BK3].p[1] = mul64(dv_ctx[4].m[0][2], dv_ctx[4].x[2]);

      r0 = sat32(ext(st_ff[S_BK3].y[0]) -
                 (asr_q(st_ff[S_BK3].p[0]) + asr_q(st_ff[S_BK3].p[1])));
      st_in[S_BK4]     = st_ff[S_BK3];
      st_in[S_BK4].t   = r0[31:0];
      st_in[S_BK4].ovf = st_ff[S_BK3].ovf | r0[32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NST; s++) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   // singular systems report zero solution and no overflow
   assign out_push = en && dv_ovld[5];

   always_comb begin
      out_item.singular = dv_ctx[5].sing;
      out_item.overflow = dv_ctx[5].ovf & ~dv_ctx[5].sing;
      out_item.x1       = dv_ctx[5].sing ? '0 : $signed(dv_ctx[5].x[0]);
      out_item.x2       = dv_ctx[5].sing ? '0 : $signed(dv_ctx[5].x[1]);
      out_item.x3       = dv_ctx[5].sing ? '0 : $signed(dv_ctx[5].x[2]);
   end

endmodule
